// ===== src/iis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_pkg
// Shared types and constants of the inverter init sequencer: phases, register
// map, command frame bytes and the structs passed between modules.
// ----------------------------------------------------------------------------
package iis_pkg;

  typedef enum logic [3:0] {
    PH_CLEAR     = 4'd0,
    PH_BRIDGE    = 4'd1,
    PH_DISABLE   = 4'd2,
    PH_ENABLE_TX = 4'd3,
    PH_REMOVE    = 4'd4,
    PH_ACC       = 4'd5,
    PH_DEC       = 4'd6,
    PH_DONE      = 4'd7,
    PH_FAILED    = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    REG_POLL_INTERVAL = 2'd0,
    REG_TIMEOUT       = 2'd1,
    REG_FRAME_ID      = 2'd2
  } reg_index_t;

  localparam logic [15:0] POLL_INTERVAL_RESET = 16'd101;
  localparam logic [15:0] TIMEOUT_RESET       = 16'd2000;
  localparam logic [10:0] FRAME_ID_RESET      = 11'd513;

  localparam logic [23:0] CMD_CLEAR_ERRORS   = 24'h8E_00_00;
  localparam logic [23:0] CMD_REQ_BRIDGE     = 24'h3D_E2_00;
  localparam logic [23:0] CMD_DISABLE        = 24'h51_04_00;
  localparam logic [23:0] CMD_REQ_ENABLE     = 24'h3D_E8_00;
  localparam logic [23:0] CMD_REMOVE_DISABLE = 24'h51_00_00;
  localparam logic [23:0] CMD_ACCEL_RAMP     = 24'h35_F4_01;
  localparam logic [23:0] CMD_DECEL_RAMP     = 24'hED_E8_03;

  typedef struct packed {
    logic [15:0] poll_interval_ms;
    logic [15:0] timeout_ms;
    logic [10:0] command_frame_id;
  } iis_cfg_t;

  typedef struct packed {
    logic        func;
    logic [31:0] now_ms;
    logic        bridge_ready;
    logic        transmit_enabled;
  } iis_item_t;

  typedef struct packed {
    logic        send_frame;
    logic [10:0] frame_id;
    logic [7:0]  frame_byte0;
    logic [7:0]  frame_byte1;
    logic [7:0]  frame_byte2;
    logic        init_done;
    logic        init_failed;
    phase_t      phase;
  } iis_result_t;

endpackage

// ===== src/iis_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_cfg_regs
// APB-style register bank: poll interval, acknowledge timeout and command
// frame identifier.
// ----------------------------------------------------------------------------
module iis_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output iis_pkg::iis_cfg_t  cfg
);
  import iis_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_interval_ms <= POLL_INTERVAL_RESET;
      cfg.timeout_ms       <= TIMEOUT_RESET;
      cfg.command_frame_id <= FRAME_ID_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POLL_INTERVAL: cfg.poll_interval_ms <= pwdata[15:0];
        REG_TIMEOUT:       cfg.timeout_ms       <= pwdata[15:0];
        REG_FRAME_ID:      cfg.command_frame_id <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POLL_INTERVAL: prdata = {16'd0, cfg.poll_interval_ms};
      REG_TIMEOUT:       prdata = {16'd0, cfg.timeout_ms};
      REG_FRAME_ID:      prdata = {21'd0, cfg.command_frame_id};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/iis_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iis_core
// Sequencer state machine and time compares. Works on the registered item and
// updates its state when the item moves into the result register.
// ----------------------------------------------------------------------------
module iis_core (
  input  logic                 clk,
  input  logic                 rst,
  input  iis_pkg::iis_cfg_t    cfg,
  input  logic                 step,
  input  iis_pkg::iis_item_t   item,
  output iis_pkg::iis_result_t result
);
  import iis_pkg::*;

  phase_t      seq_phase, seq_phase_next;
  logic [31:0] start_time, start_time_next;
  logic [31:0] last_request_time, last_request_time_next;
  logic        disable_removed, disable_removed_next;

  logic [31:0] since_request;
  logic [31:0] since_start;
  logic        interval_passed;
  logic        timed_out;
  logic        send;
  logic [23:0] cmd;

  assign since_request   = item.now_ms - last_request_time;
  assign since_start     = item.now_ms - start_time;
  assign interval_passed = since_request >= {16'd0, cfg.poll_interval_ms};
  assign timed_out       = since_start >= {16'd0, cfg.timeout_ms};

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_phase         <= PH_CLEAR;
      start_time        <= 32'd0;
      last_request_time <= 32'd0;
      disable_removed   <= 1'b0;
    end else if (step) begin
      seq_phase         <= seq_phase_next;
      start_time        <= start_time_next;
      last_request_time <= last_request_time_next;
      disable_removed   <= disable_removed_next;
    end
  end

  always_comb begin
    seq_phase_next         = seq_phase;
    start_time_next        = start_time;
    last_request_time_next = last_request_time;
    disable_removed_next   = disable_removed;
    send                   = 1'b0;
    cmd                    = 24'd0;
    if (item.func) begin
      seq_phase_next         = PH_CLEAR;
      start_time_next        = item.now_ms;
      last_request_time_next = 32'd0;
      disable_removed_next   = 1'b0;
    end else begin
      unique case (seq_phase)
        PH_CLEAR: begin
          send           = 1'b1;
          cmd            = CMD_CLEAR_ERRORS;
          seq_phase_next = PH_BRIDGE;
        end
        PH_BRIDGE: begin
          if (interval_passed) begin
            send                   = 1'b1;
            cmd                    = CMD_REQ_BRIDGE;
            last_request_time_next = item.now_ms;
          end
          if (item.bridge_ready) begin
            seq_phase_next       = PH_DISABLE;
            disable_removed_next = 1'b0;
          end else if (timed_out) begin
            seq_phase_next = PH_FAILED;
          end
        end
        PH_DISABLE: begin
          send           = 1'b1;
          cmd            = CMD_DISABLE;
          seq_phase_next = PH_ENABLE_TX;
        end
        PH_ENABLE_TX: begin
          if (interval_passed) begin
            send                   = 1'b1;
            cmd                    = CMD_REQ_ENABLE;
            last_request_time_next = item.now_ms;
          end
          if (item.transmit_enabled) begin
            seq_phase_next         = PH_REMOVE;
            disable_removed_next   = 1'b0;
            start_time_next        = item.now_ms;
            last_request_time_next = item.now_ms;
          end else if (timed_out) begin
            seq_phase_next = PH_FAILED;
          end
        end
        PH_REMOVE: begin
          if (!disable_removed) begin
            send                 = 1'b1;
            cmd                  = CMD_REMOVE_DISABLE;
            disable_removed_next = 1'b1;
            seq_phase_next       = PH_ACC;
          end
        end
        PH_ACC: begin
          send           = 1'b1;
          cmd            = CMD_ACCEL_RAMP;
          seq_phase_next = PH_DEC;
        end
        PH_DEC: begin
          send           = 1'b1;
          cmd            = CMD_DECEL_RAMP;
          seq_phase_next = PH_DONE;
        end
        default: ;
      endcase
    end

    result.send_frame  = send;
    result.frame_id    = send ? cfg.command_frame_id : 11'd0;
    result.frame_byte0 = cmd[23:16];
    result.frame_byte1 = cmd[15:8];
    result.frame_byte2 = cmd[7:0];
    result.init_done   = (seq_phase_next == PH_DONE);
    result.init_failed = (seq_phase_next == PH_FAILED);
    result.phase       = seq_phase_next;
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    step && item.func |=> seq_phase == PH_CLEAR && last_request_time == 32'd0
      && !disable_removed)
    else $error("restart did not return sequencer to clear-errors");

  a_terminal_holds: assert property (@(posedge clk) disable iff (rst)
    step && !item.func && (seq_phase == PH_DONE || seq_phase == PH_FAILED)
      |=> seq_phase == $past(seq_phase))
    else $error("done or failed phase left without restart");

  a_request_time: assert property (@(posedge clk) disable iff (rst)
    step && !item.func && send && (seq_phase == PH_BRIDGE || seq_phase == PH_ENABLE_TX)
      |=> last_request_time == $past(item.now_ms))
    else $error("request sent without updating last request time");

  a_no_step_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(seq_phase) && $stable(start_time))
    else $error("sequencer state moved without a transfer");

endmodule

// ===== src/inverter_init_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverter_init_sequencer_unit
// Power-up sequencer for a CAN-commanded motor inverter.
//
// Input channel (in_valid/in_stall): one poll or restart per transfer, with
// the current millisecond time and the two acknowledge flags. Output channel
// (out_valid/out_stall): exactly one result per input transfer, carrying an
// optional three-byte command frame, the new phase and done/failed flags. The
// user does configuration via the APB-style port only while idle (unchecked).
//
// An item is registered on input, evaluated combinationally by the core and
// lands in the result register, which drives out_valid. Throughput is one
// item per clock while the receiver does not stall, limited by the state
// update of the phase machine.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall rises only once both are occupied, so no item is lost.
// Synchronous reset empties both registers, returns the phase to clear-errors,
// zeroes the recorded times and loads the register reset values.
// ----------------------------------------------------------------------------
module inverter_init_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] now_ms,
  input  logic        bridge_ready,
  input  logic        transmit_enabled,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        send_frame,
  output logic [10:0] frame_id,
  output logic [7:0]  frame_byte0,
  output logic [7:0]  frame_byte1,
  output logic [7:0]  frame_byte2,
  output logic        init_done,
  output logic        init_failed,
  output logic [3:0]  phase
);
  import iis_pkg::*;

  iis_cfg_t    cfg;
  iis_item_t   item;
  logic        item_valid;
  iis_result_t core_result;
  iis_result_t result;
  logic        out_free;
  logic        step;

  assign out_free = !out_valid || !out_stall;
  assign step     = item_valid && out_free;
  assign in_stall = item_valid && !out_free;

  iis_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.func             <= func;
      item.now_ms           <= now_ms;
      item.bridge_ready     <= bridge_ready;
      item.transmit_enabled <= transmit_enabled;
    end
  end

  iis_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .item   (item),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= core_result;
    end
  end

  assign send_frame  = result.send_frame;
  assign frame_id    = result.frame_id;
  assign frame_byte0 = result.frame_byte0;
  assign frame_byte1 = result.frame_byte1;
  assign frame_byte2 = result.frame_byte2;
  assign init_done   = result.init_done;
  assign init_failed = result.init_failed;
  assign phase       = result.phase;

endmodule
